### hw/rtl/ulf_pkg.sv
// ----------------------------------------------------------------------------
// ulf_pkg: shared types and constants of the UTF-8 to ASCII filter
// Beat payload types, lead byte decode masks and the Latin-1 fold table.
// ----------------------------------------------------------------------------
package ulf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       char_valid;
    logic       end_of_string;
  } out_item_t;

  localparam logic [15:0] MAX_CHARS_RESET = 16'd255;
  localparam logic [15:0] CHARS_SAT       = 16'hFFFF;

  // Register index of max_chars on the configuration port.
  localparam logic REG_MAX_CHARS = 1'b0;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [6:0] QMARK_CHAR = 7'h3F;
  // Lead bits of U+00C0..U+00FF.
  localparam logic [4:0] LATIN1_HI_LEAD = 5'd3;

  // Base letters for U+00C0..U+00FF; zero marks the multiply and divide signs.
  localparam logic [6:0] FOLD_TABLE [64] = '{
    7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h41, 7'h43,
    7'h45, 7'h45, 7'h45, 7'h45, 7'h49, 7'h49, 7'h49, 7'h49,
    7'h44, 7'h4E, 7'h4F, 7'h4F, 7'h4F, 7'h4F, 7'h4F, 7'h00,
    7'h4F, 7'h55, 7'h55, 7'h55, 7'h55, 7'h59, 7'h54, 7'h73,
    7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h63,
    7'h65, 7'h65, 7'h65, 7'h65, 7'h69, 7'h69, 7'h69, 7'h69,
    7'h64, 7'h6E, 7'h6F, 7'h6F, 7'h6F, 7'h6F, 7'h6F, 7'h00,
    7'h6F, 7'h75, 7'h75, 7'h75, 7'h75, 7'h79, 7'h74, 7'h79
  };

  // Character of a 2-byte sequence as {valid, char}.
  function automatic logic [7:0] fold_pair(input logic [4:0] lead5, input logic [5:0] low6);
    logic [6:0] c;
    begin
      if (lead5 == LATIN1_HI_LEAD) begin
        c = FOLD_TABLE[low6];
        fold_pair = {(c != 7'd0), c};
      end else begin
        fold_pair = {1'b1, QMARK_CHAR};
      end
    end
  endfunction

endpackage

### hw/rtl/utf8_latin1_to_ascii_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_latin1_to_ascii_filter_unit: UTF-8 to ASCII transliteration filter
// Folds Latin-1 letters to base letters, drops multiply/divide, rest as '?'.
// ----------------------------------------------------------------------------
// An accepted beat waits in the input register; its result then goes into
// the result register once that register is empty or being read out.
// Throughput: one byte per cycle while results are taken; the decode between
// the input and result registers is a single table lookup plus string state.
// Reset (synchronous, active low) empties both stages, clears string state
// and sets max_chars to 255.
module utf8_latin1_to_ascii_filter_unit import ulf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_chars_r;
  logic        advance;
  logic        item_valid;
  in_item_t    item;
  logic        has_result;
  out_item_t   result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_CHARS) ? {16'd0, max_chars_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_CHARS) begin
      max_chars_r <= pwdata[15:0];
    end
  end

  ulf_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ulf_xlat u_xlat (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_chars  (max_chars_r),
    .fire       (item_valid && advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  ulf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .can_load   (advance),
    .load_valid (item_valid && has_result),
    .load_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.out_char == 7'd0)
    else $error("character field set on a beat without a character");

  a_no_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.end_of_string)
    else $error("result beat carries neither character nor end mark");

endmodule

### hw/rtl/ulf_in_reg.sv
// ----------------------------------------------------------------------------
// ulf_in_reg: input register stage
// Holds one accepted beat until the translation stage moves it on.
// ----------------------------------------------------------------------------
module ulf_in_reg import ulf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t data_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

### hw/rtl/ulf_xlat.sv
// ----------------------------------------------------------------------------
// ulf_xlat: byte translation and string state
// Decodes one byte against the string state and forms the result, if any.
// ----------------------------------------------------------------------------
module ulf_xlat import ulf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_chars,
  input  logic        fire,
  input  in_item_t    item,
  output logic        has_result,
  output out_item_t   result
);

  logic [1:0]  skip_r, skip_nxt;
  logic        await_r, await_nxt;
  logic [4:0]  lead_r, lead_nxt;
  logic [15:0] count_r, count_nxt;
  logic        stopped_r, stopped_nxt;

  logic [7:0] b;
  logic       last;
  logic       vld;
  logic [6:0] ch;

  assign b    = item.in_byte;
  assign last = item.is_last;

  always_comb begin
    skip_nxt    = skip_r;
    await_nxt   = await_r;
    lead_nxt    = lead_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    vld         = 1'b0;
    ch          = 7'd0;

    if (stopped_r) begin
      vld = 1'b0;
    end else if (skip_r != 2'd0) begin
      if (b == 8'd0) begin
        stopped_nxt = 1'b1;
      end else begin
        skip_nxt = skip_r - 2'd1;
      end
    end else if (await_r) begin
      await_nxt = 1'b0;
      {vld, ch} = fold_pair(lead_r, b[5:0]);
      if (b == 8'd0) begin
        stopped_nxt = 1'b1;
      end
    end else if (b == 8'd0 || count_r >= max_chars) begin
      stopped_nxt = 1'b1;
    end else if (!b[7]) begin
      ch  = b[6:0];
      vld = 1'b1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      lead_nxt = b[4:0];
      // A string that ends on the lead takes the low bits as zero.
      if (last) begin
        {vld, ch} = fold_pair(b[4:0], 6'd0);
      end else begin
        await_nxt = 1'b1;
      end
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      ch       = QMARK_CHAR;
      vld      = 1'b1;
      skip_nxt = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      ch       = QMARK_CHAR;
      vld      = 1'b1;
      skip_nxt = 2'd3;
    end

    if (vld && count_r != CHARS_SAT) begin
      count_nxt = count_r + 16'd1;
    end
    if (!vld) begin
      ch = 7'd0;
    end

    if (last) begin
      skip_nxt    = 2'd0;
      await_nxt   = 1'b0;
      lead_nxt    = 5'd0;
      count_nxt   = 16'd0;
      stopped_nxt = 1'b0;
    end

    has_result           = vld || last;
    result.out_char      = ch;
    result.char_valid    = vld;
    result.end_of_string = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r    <= 2'd0;
      await_r   <= 1'b0;
      lead_r    <= 5'd0;
      count_r   <= 16'd0;
      stopped_r <= 1'b0;
    end else if (fire) begin
      skip_r    <= skip_nxt;
      await_r   <= await_nxt;
      lead_r    <= lead_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

### hw/rtl/ulf_out_reg.sv
// ----------------------------------------------------------------------------
// ulf_out_reg: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ulf_out_reg import ulf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  output logic      can_load,
  input  logic      load_valid,
  input  out_item_t load_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule
